[rtl/csf_pkg.sv]
// Shared constants and types for the coprime sieve filter.
// Used by csf_div and coprime_sieve_filter_top; depends on nothing.
package csf_pkg;

  localparam int MapDepth = 4096;
  localparam int AddrW    = 12;
  localparam int ValW     = 16;
  localparam int CntW     = 13;
  localparam int DivW     = 9;
  localparam int WideW    = 17;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TEST   = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } csf_div_sts_t;

endpackage

[rtl/coprime_sieve_filter_top.sv]
// Coprime sieve filter: mark map in a 4096 x 1 memory, trial-division sequencer.
// Depends on csf_pkg and csf_div.
// Operation: insert tries each trial divisor up to sqrt(value) and marks the multiples;
//   search scans entries in turn; every command ends with a recount pass over
//   entries 1..min(m_limit, 4096) through the single memory read port.
// Throughput: one item at a time; in_stall is high until the item's work is done.
// Reset: a clearing pass sweeps all 4096 map entries; no item is taken meanwhile.
module coprime_sieve_filter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [csf_pkg::ValW-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csf_pkg::CntW-1:0]    out_survivor_count,
  output logic                        out_hit,
  output logic [csf_pkg::CntW-1:0]    out_found_value,
  input  logic                        cfg_we,
  input  logic [csf_pkg::CntW-1:0]    cfg_data
);
  import csf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_LOOP  = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_FCHK  = 4'd4;
  localparam logic [3:0] ST_FWAIT = 4'd5;
  localparam logic [3:0] ST_MARK  = 4'd6;
  localparam logic [3:0] ST_AFTER = 4'd7;
  localparam logic [3:0] ST_SRCH  = 4'd8;
  localparam logic [3:0] ST_SWAIT = 4'd9;
  localparam logic [3:0] ST_TWAIT = 4'd10;
  localparam logic [3:0] ST_CSET  = 4'd11;
  localparam logic [3:0] ST_COUNT = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  localparam logic [1:0] PH_DIV   = 2'd0;
  localparam logic [1:0] PH_COF   = 2'd1;
  localparam logic [1:0] PH_SELF  = 2'd2;

  logic [3:0]       state_r, state_nxt;
  logic             boot_r, boot_nxt;
  logic [CntW-1:0]  m_limit_r;
  logic [ValW-1:0]  val_r, val_nxt, q_r, q_nxt;
  logic [DivW-1:0]  i_r, i_nxt;
  logic [WideW-1:0] sq_r, sq_nxt, d_r, d_nxt, x_r, x_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic             hit_r, hit_nxt, pend_r, pend_nxt;
  logic [CntW-1:0]  found_r, found_nxt, excl_r, excl_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CntW-1:0]  out_cnt_r, out_found_r;
  logic             out_hit_r, load_out;

  logic [CntW-1:0]  lim;
  logic [WideW-1:0] lim_w;
  logic             mem_we, mem_wd, rdata_r;
  logic [AddrW-1:0] mem_wa, rd_addr;
  logic             mem [MapDepth];

  logic             div_start;
  csf_div_sts_t     div_sts;
  logic [ValW-1:0]  div_q;
  logic [DivW-1:0]  div_rem;

  csf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (val_r),
    .divisor  (i_r),
    .sts      (div_sts),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // effective limit saturates at the map depth
  assign lim   = (m_limit_r > CntW'(MapDepth)) ? CntW'(MapDepth) : m_limit_r;
  assign lim_w = {{(WideW-CntW){1'b0}}, lim};

  assign in_stall = (state_r != ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    val_nxt   = val_r;
    q_nxt     = q_r;
    i_nxt     = i_r;
    sq_nxt    = sq_r;
    d_nxt     = d_r;
    x_nxt     = x_r;
    ph_nxt    = ph_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    excl_nxt  = excl_r;
    pend_nxt  = pend_r;
    mem_we    = 1'b0;
    mem_wa    = x_r[AddrW-1:0] - AddrW'(1);
    mem_wd    = 1'b1;
    rd_addr   = x_r[AddrW-1:0] - AddrW'(1);
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_addr = in_value[AddrW-1:0] - AddrW'(1);
        if (in_valid) begin
          val_nxt   = in_value;
          hit_nxt   = 1'b0;
          found_nxt = '0;
          case (in_cmd)
            CMD_INSERT: begin
              i_nxt     = DivW'(2);
              sq_nxt    = WideW'(4);
              state_nxt = (in_value >= ValW'(2)) ? ST_LOOP : ST_CSET;
            end
            CMD_TEST: begin
              if (in_value != '0 && {1'b0, in_value} <= lim_w) state_nxt = ST_TWAIT;
              else state_nxt = ST_CSET;
            end
            CMD_SEARCH: begin
              x_nxt     = (in_value == '0) ? WideW'(1) : {1'b0, in_value};
              state_nxt = ST_SRCH;
            end
            default: begin
              x_nxt     = '0;
              state_nxt = ST_CLR;
            end
          endcase
        end
      end
      // sweep the whole map to zero
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = x_r[AddrW-1:0];
        mem_wd = 1'b0;
        x_nxt  = x_r + WideW'(1);
        if (x_r[AddrW-1:0] == {AddrW{1'b1}}) begin
          state_nxt = boot_r ? ST_IDLE : ST_CSET;
          boot_nxt  = 1'b0;
        end
      end
      // next trial divisor, or finish with the value itself
      ST_LOOP: begin
        if (sq_r > {1'b0, val_r}) begin
          d_nxt     = {1'b0, val_r};
          x_nxt     = {1'b0, val_r};
          ph_nxt    = PH_SELF;
          state_nxt = ST_MARK;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            q_nxt     = div_q;
            d_nxt     = WideW'(i_r);
            ph_nxt    = PH_DIV;
            state_nxt = ST_FCHK;
          end else begin
            i_nxt     = i_r + DivW'(1);
            sq_nxt    = sq_r + WideW'({i_r, 1'b1});
            state_nxt = ST_LOOP;
          end
        end
      end
      // skip a divisor out of range or already marked
      ST_FCHK: begin
        rd_addr = d_r[AddrW-1:0] - AddrW'(1);
        if (d_r != '0 && d_r <= lim_w) state_nxt = ST_FWAIT;
        else state_nxt = ST_AFTER;
      end
      ST_FWAIT: begin
        if (!rdata_r) begin
          x_nxt     = d_r;
          state_nxt = ST_MARK;
        end else begin
          state_nxt = ST_AFTER;
        end
      end
      // mark one multiple per cycle
      ST_MARK: begin
        if (x_r <= lim_w) begin
          mem_we = 1'b1;
          x_nxt  = x_r + d_r;
        end else begin
          state_nxt = ST_AFTER;
        end
      end
      ST_AFTER: begin
        case (ph_r)
          PH_DIV: begin
            d_nxt     = {1'b0, q_r};
            ph_nxt    = PH_COF;
            state_nxt = ST_FCHK;
          end
          PH_COF: begin
            i_nxt     = i_r + DivW'(1);
            sq_nxt    = sq_r + WideW'({i_r, 1'b1});
            state_nxt = ST_LOOP;
          end
          default: state_nxt = ST_CSET;
        endcase
      end
      ST_SRCH: begin
        if (x_r > lim_w) state_nxt = ST_CSET;
        else state_nxt = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (!rdata_r) begin
          hit_nxt   = 1'b1;
          found_nxt = x_r[CntW-1:0];
          state_nxt = ST_CSET;
        end else begin
          x_nxt     = x_r + WideW'(1);
          state_nxt = ST_SRCH;
        end
      end
      ST_TWAIT: begin
        hit_nxt   = !rdata_r;
        state_nxt = ST_CSET;
      end
      ST_CSET: begin
        x_nxt     = WideW'(1);
        excl_nxt  = '0;
        pend_nxt  = 1'b0;
        state_nxt = ST_COUNT;
      end
      // recount marks over 1..limit, reads pipelined one deep
      ST_COUNT: begin
        if (pend_r) excl_nxt = excl_r + CntW'(rdata_r);
        if (x_r <= lim_w) begin
          x_nxt    = x_r + WideW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      boot_r      <= 1'b1;
      x_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      m_limit_r   <= CntW'(MapDepth);
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      x_r         <= x_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) m_limit_r <= cfg_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    q_r     <= q_nxt;
    i_r     <= i_nxt;
    sq_r    <= sq_nxt;
    d_r     <= d_nxt;
    ph_r    <= ph_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    excl_r  <= excl_nxt;
    if (load_out) begin
      out_cnt_r   <= lim - excl_r;
      out_hit_r   <= hit_r;
      out_found_r <= found_r;
    end
  end

  // mark map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[rd_addr];
  end

  assign out_valid          = out_valid_r;
  assign out_survivor_count = out_cnt_r;
  assign out_hit            = out_hit_r;
  assign out_found_value    = out_found_r;

  // marking only ever runs with a divisor of at least two
  a_mark_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (d_r >= WideW'(2)))
    else $error("mark step with divisor below two");

  // never more marks counted than the limit
  a_count_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (excl_r <= lim))
    else $error("mark count exceeds limit");

  // no item taken during the reset clearing pass
  a_boot_stall: assert property (@(posedge clk) disable iff (!rst_n)
    boot_r |-> in_stall)
    else $error("item accepted during clearing pass");

  // a result is loaded only once the recount has finished
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !pend_r)
    else $error("result loaded with a count read pending");

endmodule

[rtl/csf_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on csf_pkg.
module csf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [csf_pkg::ValW-1:0]     dividend,
  input  logic [csf_pkg::DivW-1:0]     divisor,
  output csf_pkg::csf_div_sts_t        sts,
  output logic [csf_pkg::ValW-1:0]     quot,
  output logic [csf_pkg::DivW-1:0]     rem
);
  import csf_pkg::*;

  logic [ValW-1:0] dvd_r, dvd_nxt;
  logic [DivW-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DivW:0]   trial;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[ValW-1]};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = 4'd15;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DivW'(trial - {1'b0, dsr_r});
        dvd_nxt = {dvd_r[ValW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DivW-1:0];
        dvd_nxt = {dvd_r[ValW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = dvd_r;
  assign rem      = rem_r;

endmodule
